// ===== src/dni_pkg.sv =====
// Shared types, constants and the mode-step function of the daughter nuclide calculator.
`timescale 1ns / 1ps
`default_nettype none
package dni_pkg;

  localparam int NUM_MODE_INPUTS = 5;
  localparam int DEF_MAX_MODES   = 5;
  localparam int MODE_W          = 18;
  localparam int ID_W            = 21;
  localparam int ST_W            = 4;
  localparam int ZA_W            = 18;
  localparam int PROD_W          = 23;
  localparam int ERR_W           = 3;
  localparam int ZW              = 12;  // signed Z and A after the chain
  localparam int SW              = 24;  // signed identifiers and differences
  localparam int FIFO_DEPTH      = 4;

  localparam logic [ERR_W-1:0] ERR_OK        = 3'd0;
  localparam logic [ERR_W-1:0] ERR_IT_GROUND = 3'd1;
  localparam logic [ERR_W-1:0] ERR_INEL_SAME = 3'd2;
  localparam logic [ERR_W-1:0] ERR_Z_ZERO    = 3'd3;
  localparam logic [ERR_W-1:0] ERR_BAD_IT    = 3'd4;

  localparam logic [MODE_W-1:0] MT_INELASTIC = 18'd4;
  localparam logic [MODE_W-1:0] MT_DECAY     = 18'd10000;
  localparam logic [MODE_W-1:0] MT_BETA_M    = 18'd10001;
  localparam logic [MODE_W-1:0] MT_BETA_P    = 18'd10002;
  localparam logic [MODE_W-1:0] MT_IT        = 18'd10003;
  localparam logic [MODE_W-1:0] MT_ALPHA     = 18'd10004;
  localparam logic [MODE_W-1:0] MT_NEUTRON   = 18'd10005;
  localparam logic [MODE_W-1:0] MT_SF        = 18'd10006;
  localparam logic [MODE_W-1:0] MT_PROTON    = 18'd10007;
  localparam logic [MODE_W-1:0] MT_SECONDARY = 18'd20000;
  localparam logic [MODE_W-1:0] MT_NT2A      = 18'd113;
  localparam logic [MODE_W-1:0] MT_N2A       = 18'd108;

  localparam logic signed [SW-1:0] ACC_DIFF [32] = '{
    24'sd1, -24'sd1, -24'sd2, -24'sd3, 24'sd999, -24'sd1000, 24'sd1000, -24'sd1001,
    -24'sd1002, -24'sd1004, -24'sd2003, -24'sd2004, -24'sd2005, -24'sd2006, -24'sd6012,
    -24'sd4007, -24'sd2002, -24'sd3005, -24'sd3004, -24'sd1003, -24'sd2001, -24'sd4008,
    -24'sd4009, -24'sd5009, -24'sd5010, -24'sd6011, 24'sd0, -24'sd2000, 24'sd2000,
    24'sd998, 24'sd997, 24'sd996
  };

  typedef logic [MODE_W-1:0] mode_t;

  // Record after splitting the parent identifier.
  typedef struct packed {
    logic                             early;  // skip or natural parent
    logic [ID_W-1:0]                  zai;
    logic [ZA_W-1:0]                  za;
    logic [7:0]                       z;
    logic [9:0]                       a;
    logic [ST_W-1:0]                  i;
    logic [ST_W-1:0]                  inc;
    logic [ST_W-1:0]                  fin;
    mode_t [NUM_MODE_INPUTS-1:0]      modes;
  } rec_t;

  // Record while walking the mode chain.
  typedef struct packed {
    logic                             done;
    logic                             ended;
    logic signed [ZW-1:0]             z;
    logic signed [ZW-1:0]             a;
    logic [ST_W-1:0]                  i;
    logic signed [PROD_W-1:0]         prod;
    logic [ERR_W-1:0]                 err;
    logic [ID_W-1:0]                  zai;
    logic [ZA_W-1:0]                  za;
    logic [ST_W-1:0]                  inc;
    logic [ST_W-1:0]                  fin;
    mode_t                            m0;
  } work_t;

  // Apply one chained mode code.
  function automatic work_t dni_step(work_t w_in, mode_t mt_in);
    work_t w;
    mode_t mt;
    logic signed [4:0] da;
    logic signed [4:0] dz;
    logic [PROD_W-1:0] sec;
    w  = w_in;
    mt = mt_in;
    da = '0;
    dz = '0;
    sec = PROD_W'((PROD_W'(mt_in) - PROD_W'(MT_SECONDARY)) * PROD_W'(10));
    if (!w.done && !w.ended) begin
      if (mt == '0 || mt == MT_DECAY) begin
        w.ended = 1'b1;
      end else begin
        if (w.z == 12'sd5 && w.a == 12'sd10 && w.i == '0 && mt == MT_NT2A) begin
          mt = MT_N2A;
        end
        if (mt == 18'd18 || mt == 18'd19 || mt == 18'd20 || mt == 18'd21 ||
            mt == 18'd38) begin
          w.done = 1'b1;
          w.prod = -23'sd1;
        end else begin
          case (mt)
            18'd16:  begin da = -5'sd1;  dz = 5'sd0;  end
            18'd17:  begin da = -5'sd2;  dz = 5'sd0;  end
            18'd22:  begin da = -5'sd4;  dz = -5'sd2; end
            18'd23:  begin da = -5'sd12; dz = -5'sd6; end
            18'd24:  begin da = -5'sd5;  dz = -5'sd2; end
            18'd25:  begin da = -5'sd6;  dz = -5'sd2; end
            18'd28:  begin da = -5'sd1;  dz = -5'sd1; end
            18'd29:  begin da = -5'sd8;  dz = -5'sd4; end
            18'd30:  begin da = -5'sd9;  dz = -5'sd4; end
            18'd32:  begin da = -5'sd2;  dz = -5'sd1; end
            18'd33:  begin da = -5'sd3;  dz = -5'sd1; end
            18'd34:  begin da = -5'sd3;  dz = -5'sd2; end
            18'd35:  begin da = -5'sd10; dz = -5'sd5; end
            18'd36:  begin da = -5'sd11; dz = -5'sd5; end
            18'd37:  begin da = -5'sd3;  dz = 5'sd0;  end
            18'd41:  begin da = -5'sd2;  dz = -5'sd1; end
            18'd42:  begin da = -5'sd3;  dz = -5'sd1; end
            18'd44:  begin da = -5'sd2;  dz = -5'sd2; end
            18'd45:  begin da = -5'sd5;  dz = -5'sd3; end
            18'd102: begin da = 5'sd1;   dz = 5'sd0;  end
            18'd103: begin da = 5'sd0;   dz = -5'sd1; end
            18'd104: begin da = -5'sd1;  dz = -5'sd1; end
            18'd105: begin da = -5'sd2;  dz = -5'sd1; end
            18'd106: begin da = -5'sd2;  dz = -5'sd2; end
            18'd107: begin da = -5'sd3;  dz = -5'sd2; end
            18'd108: begin da = -5'sd7;  dz = -5'sd4; end
            18'd109: begin da = -5'sd11; dz = -5'sd6; end
            18'd111: begin da = -5'sd1;  dz = -5'sd2; end
            18'd112: begin da = -5'sd4;  dz = -5'sd3; end
            18'd113: begin da = -5'sd10; dz = -5'sd5; end
            18'd114: begin da = -5'sd9;  dz = -5'sd5; end
            18'd115: begin da = -5'sd2;  dz = -5'sd2; end
            18'd116: begin da = -5'sd3;  dz = -5'sd2; end
            18'd117: begin da = -5'sd5;  dz = -5'sd3; end
            MT_BETA_M:  dz = 5'sd1;
            MT_BETA_P:  dz = -5'sd1;
            MT_ALPHA:   begin da = -5'sd4; dz = -5'sd2; end
            MT_NEUTRON: da = -5'sd1;
            MT_PROTON:  begin da = -5'sd1; dz = -5'sd1; end
            MT_IT: begin
              if (w.i == '0) begin
                w.done = 1'b1;
                w.err  = ERR_IT_GROUND;
                w.prod = '0;
              end else begin
                w.i = '0;
              end
            end
            MT_SF: begin
              w.done = 1'b1;
              w.prod = -23'sd2;
            end
            default: ;
          endcase
          w.a = w.a + ZW'(da);
          w.z = w.z + ZW'(dz);
          if (!w.done) begin
            if (mt > MT_SECONDARY) begin
              w.done = 1'b1;
              w.prod = $signed(sec);
            end else begin
              if (mt > 18'd599 && mt < 18'd650) w.z = w.z - 12'sd1;
              if (mt > 18'd649 && mt < 18'd700) begin
                w.a = w.a - 12'sd1; w.z = w.z - 12'sd1;
              end
              if (mt > 18'd699 && mt < 18'd750) begin
                w.a = w.a - 12'sd2; w.z = w.z - 12'sd1;
              end
              if (mt > 18'd749 && mt < 18'd800) begin
                w.a = w.a - 12'sd2; w.z = w.z - 12'sd2;
              end
              if (mt > 18'd799 && mt < 18'd850) begin
                w.a = w.a - 12'sd3; w.z = w.z - 12'sd2;
              end
              if (mt > 18'd874 && mt < 18'd892) w.a = w.a - 12'sd1;
            end
          end
        end
      end
    end
    return w;
  endfunction

endpackage
`default_nettype wire

// ===== src/dni_front.sv =====
// Front end: accepts words and splits the parent identifier into Z, A and I.
`timescale 1ns / 1ps
`default_nettype none
module dni_front
  import dni_pkg::*;
(
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic                         skip,
  input  wire logic [ID_W-1:0]              zai,
  input  wire logic [ST_W-1:0]              inc,
  input  wire logic [ST_W-1:0]              fin,
  input  wire mode_t [NUM_MODE_INPUTS-1:0]  modes,
  output logic                              push,
  output rec_t                              push_rec,
  input  wire logic                         full
);

  rec_t f1, f2, f3;
  rec_t f1_next, f2_next, f3_next;
  logic v1, v2, v3;
  logic en1, en2, en3;
  logic [52:0] p1;
  logic [49:0] p2;

  assign en3 = !v3 || !full;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign in_ready = en1;
  assign push = v3 && !full;
  assign push_rec = f3;

  // reciprocal multiplies for /10 and /1000
  assign p1 = 53'(zai) * 53'(32'hCCCCCCCD);
  assign p2 = 50'(f1.za) * 50'(32'h10624DD3);

  always_comb begin
    f1_next       = '0;
    f1_next.early = skip;
    f1_next.zai   = zai;
    f1_next.za    = p1[52:35];
    f1_next.inc   = inc;
    f1_next.fin   = fin;
    f1_next.modes = modes;

    f2_next   = f1;
    f2_next.z = p2[45:38];
    f2_next.i = ST_W'(f1.zai - (ID_W'(f1.za) << 3) - (ID_W'(f1.za) << 1));

    f3_next       = f2;
    f3_next.a     = 10'(f2.za - ZA_W'(f2.z) * ZA_W'(1000));
    f3_next.early = f2.early || (f3_next.a == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (en1) v1 <= in_valid;
      if (en2) v2 <= v1;
      if (en3) v3 <= v2;
    end
    if (en1) f1 <= f1_next;
    if (en2) f2 <= f2_next;
    if (en3) f3 <= f3_next;
  end

endmodule
`default_nettype wire

// ===== src/dni_fifo.sv =====
// Short queue of split records between front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module dni_fifo
  import dni_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire rec_t push_rec,
  output logic      full,
  input  wire logic pop,
  output rec_t      head,
  output logic      empty
);

  localparam int AW = $clog2(FIFO_DEPTH);

  rec_t mem [FIFO_DEPTH];
  logic [AW:0] wptr, rptr;

  assign empty = (wptr == rptr);
  assign full  = (wptr[AW] != rptr[AW]) && (wptr[AW-1:0] == rptr[AW-1:0]);
  assign head  = mem[rptr[AW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
    end
    if (push) mem[wptr[AW-1:0]] <= push_rec;
  end

endmodule
`default_nettype wire

// ===== src/dni_back.sv =====
// Back end: mode chain stages, daughter checks and the output register.
`timescale 1ns / 1ps
`default_nettype none
module dni_back
  import dni_pkg::*;
#(
  parameter int MAX_MODES = DEF_MAX_MODES
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 empty,
  input  wire rec_t                 head,
  output logic                      pop,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic signed [PROD_W-1:0]  product_code,
  output logic [ERR_W-1:0]          error_code,
  output logic                      unusual_change
);

  typedef struct packed {
    work_t                 w;
    logic signed [SW-1:0]  newid;
    logic signed [SW-1:0]  diff;
    logic signed [SW-1:0]  d;
    logic                  same;
  } chk_t;

  work_t st [MAX_MODES+1];
  logic  v  [MAX_MODES+1];
  logic  en;
  chk_t  cr;
  chk_t  cr_next;
  logic  cv;

  // Each stage keeps its own copy of the later codes.
  mode_t mq [MAX_MODES+1][NUM_MODE_INPUTS];

  logic signed [SW-1:0] q, newid_c, trunc_c, same_c;
  logic                 fin_ge;
  logic [ST_W-1:0]      rem;
  logic                 ok;
  logic signed [PROD_W-1:0] prod_n;
  logic [ERR_W-1:0]     err_n;
  logic                 unu_n;

  assign en  = !out_valid || out_ready;
  assign pop = en && !empty;

  always_comb begin
    st[0]       = '0;
    st[0].done  = head.early;
    st[0].z     = ZW'($signed({1'b0, head.z}));
    st[0].a     = ZW'($signed({1'b0, head.a}));
    st[0].i     = head.i;
    st[0].zai   = head.zai;
    st[0].za    = head.za;
    st[0].inc   = head.inc;
    st[0].fin   = head.fin;
    st[0].m0    = head.modes[0];
    v[0]        = !empty;
  end

  always_comb begin
    for (int k = 0; k < NUM_MODE_INPUTS; k++) mq[0][k] = head.modes[k];
  end
  for (genvar n = 0; n < MAX_MODES; n++) begin : g_mq
    always_ff @(posedge clk) begin
      if (en) mq[n+1] <= mq[n];
    end
  end

  for (genvar n = 0; n < MAX_MODES; n++) begin : g_step
    mode_t mt;
    if (n < NUM_MODE_INPUTS) begin : g_in
      assign mt = mq[n][n];
    end else begin : g_zero
      assign mt = '0;
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[n+1] <= 1'b0;
      end else if (en) begin
        v[n+1] <= v[n];
      end
      if (en) st[n+1] <= dni_step(st[n], mt);
    end
  end

  // Rebuild the daughter identifier and its ZA difference.
  always_comb begin
    q       = SW'(st[MAX_MODES].z) * SW'(1000) + SW'(st[MAX_MODES].a);
    newid_c = q * SW'(10) + SW'($signed({1'b0, st[MAX_MODES].fin}));
    same_c  = q * SW'(10) + SW'($signed({1'b0, st[MAX_MODES].i}));
    fin_ge  = st[MAX_MODES].fin >= 4'd10;
    rem     = fin_ge ? st[MAX_MODES].fin - 4'd10 : st[MAX_MODES].fin;
    trunc_c = q + SW'($signed({1'b0, fin_ge}))
                + SW'($signed({1'b0, (newid_c < 0) && (rem != '0)}));
    cr_next.w     = st[MAX_MODES];
    cr_next.newid = newid_c;
    cr_next.diff  = trunc_c - SW'($signed({1'b0, st[MAX_MODES].za}));
    cr_next.d     = SW'($signed({1'b0, st[MAX_MODES].zai})) - newid_c;
    cr_next.same  = same_c == SW'($signed({1'b0, st[MAX_MODES].zai}));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cv <= 1'b0;
    end else if (en) begin
      cv <= v[MAX_MODES];
    end
    if (en) cr <= cr_next;
  end

  always_comb begin
    ok = 1'b0;
    for (int k = 0; k < 32; k++) begin
      if (ACC_DIFF[k] == cr.diff) ok = 1'b1;
    end
    prod_n = '0;
    err_n  = ERR_OK;
    unu_n  = 1'b0;
    if (cr.w.done) begin
      prod_n = cr.w.prod;
      err_n  = cr.w.err;
    end else if (cr.w.m0 == MT_INELASTIC && cr.w.fin == cr.w.inc) begin
      err_n = ERR_INEL_SAME;
    end else if (cr.w.m0 != MT_INELASTIC && cr.w.z == '0) begin
      err_n = ERR_Z_ZERO;
    end else if (cr.w.m0 != MT_INELASTIC && cr.same) begin
      err_n = ERR_OK;
    end else if (cr.w.m0 != MT_INELASTIC && cr.diff == '0 &&
                 cr.d != 24'sd1 && cr.d != 24'sd2 && cr.d != 24'sd3) begin
      err_n = ERR_BAD_IT;
    end else begin
      prod_n = cr.newid[PROD_W-1:0];
      unu_n  = !ok;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= cv;
    end
    if (en) begin
      product_code   <= prod_n;
      error_code     <= err_n;
      unusual_change <= unu_n;
    end
  end

endmodule
`default_nettype wire

// ===== src/daughter_nuclide_id.sv =====
// Top level of the daughter nuclide calculator: stream ports, front, queue and back.
`timescale 1ns / 1ps
`default_nettype none
// Computes the daughter of a parent nuclide 10000*Z + 10*A + I under up to
// MAX_MODES chained reaction or decay codes and reports the daughter id
// (0 unchanged, -1 induced fission, -2 spontaneous fission, ten times the
// product for a secondary code), an error code and an unusual-change flag.
// One word is taken per cycle when the queue is not full, and one result word
// leaves per input word, in order. Three front stages split the identifier
// with reciprocal multiplies; then come the four-entry queue, one stage per
// chained code, one check stage and the output register. The front and back
// stall on their own through the queue.
module daughter_nuclide_id
  import dni_pkg::*;
#(
  parameter int MAX_MODES = DEF_MAX_MODES
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // parent_id[20:0], incident_state[24:21], final_state[28:25],
  // mode_primary[46:29], mode_second[64:47], mode_third[82:65],
  // mode_fourth[100:83], mode_fifth[118:101], zero[119]
  input  wire logic [119:0] s_tdata,
  // skip_reaction[0]
  input  wire logic [0:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // product_code[22:0], error_code[25:23], unusual_change[26], zero[31:27]
  output logic [31:0]       m_tdata
);

  mode_t [NUM_MODE_INPUTS-1:0] modes;
  logic  push, full, pop, empty;
  rec_t  push_rec, head;
  logic signed [PROD_W-1:0] product_code;
  logic [ERR_W-1:0] error_code;
  logic unusual_change;

  // unpack the five mode codes
  always_comb begin
    for (int k = 0; k < NUM_MODE_INPUTS; k++) begin
      modes[k] = s_tdata[29 + k*MODE_W +: MODE_W];
    end
  end

  dni_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .skip     (s_tuser[0]),
    .zai      (s_tdata[20:0]),
    .inc      (s_tdata[24:21]),
    .fin      (s_tdata[28:25]),
    .modes    (modes),
    .push     (push),
    .push_rec (push_rec),
    .full     (full)
  );

  dni_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  dni_back #(
    .MAX_MODES (MAX_MODES)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .empty          (empty),
    .head           (head),
    .pop            (pop),
    .out_valid      (m_tvalid),
    .out_ready      (m_tready),
    .product_code   (product_code),
    .error_code     (error_code),
    .unusual_change (unusual_change)
  );

  // pack the result word
  assign m_tdata = {5'b0, unusual_change, error_code, product_code};

endmodule
`default_nettype wire

// ===== sim/daughter_nuclide_id_tb.sv =====
// Testbench of the daughter nuclide calculator: directed table, random records, scoreboard.
`timescale 1ns / 1ps
`default_nettype none
module daughter_nuclide_id_tb;
  import dni_pkg::*;

  localparam int LATENCY   = DEF_MAX_MODES + 7;
  localparam int IDLE_MAX  = 2000;  // cycles with no word moving on either side
  localparam int HOLD_LEN  = 200;   // long receiver hold-off
  localparam int N_RANDOM  = 400;

  typedef struct {
    logic                        skip;
    logic [ID_W-1:0]             pid;
    logic [ST_W-1:0]             inc;
    logic [ST_W-1:0]             fin;
    mode_t [NUM_MODE_INPUTS-1:0] modes;
  } record_t;

  typedef struct {
    logic signed [PROD_W-1:0] prod;
    logic [ERR_W-1:0]         err;
    logic                     unusual;
  } daughter_t;

  typedef struct {
    record_t   rec;
    bit        typed;
    daughter_t want;
  } dir_row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [119:0] s_tdata = '0;
  logic [0:0]   s_tuser = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [31:0]  m_tdata;

  daughter_t pending_daughters[$];
  int        mismatch_cnt = 0;
  int        words_in = 0;
  int        idle_cycles = 0;
  int        hold_cnt = 0;
  bit        hold_done = 1'b0;

  daughter_nuclide_id uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  function automatic daughter_t mk_daughter(int prod, logic [ERR_W-1:0] err, bit unusual);
    daughter_t d;
    d.prod    = PROD_W'(prod);
    d.err     = err;
    d.unusual = unusual;
    return d;
  endfunction

  // Walk the mode chain in plain integers, the same way the block is specified.
  function automatic daughter_t predict_daughter(record_t r);
    int accepted [32] = '{1, -1, -2, -3, 999, -1000, 1000, -1001, -1002, -1004, -2003,
                          -2004, -2005, -2006, -6012, -4007, -2002, -3005, -3004, -1003,
                          -2001, -4008, -4009, -5009, -5010, -6011, 0, -2000, 2000, 998,
                          997, 996};
    int md [8];
    int zai, za, z, a, i, inc, fin, newid, diff, d, mt, da, dz;
    bit ok;
    if (r.skip) return mk_daughter(0, ERR_OK, 0);
    zai = int'(r.pid);
    inc = int'(r.inc);
    fin = int'(r.fin);
    foreach (md[n]) md[n] = (n < NUM_MODE_INPUTS) ? int'(r.modes[n]) : 0;
    za = zai / 10;
    z  = za / 1000;
    a  = za - 1000 * z;
    i  = zai - 10 * za;
    if (a == 0) return mk_daughter(0, ERR_OK, 0);
    for (int n = 0; n < DEF_MAX_MODES && n < 8; n++) begin
      mt = md[n];
      if (mt == int'(MT_DECAY) || mt == 0) break;
      // boron-10 (n,t2a) is booked as (n,2a)
      if (10000 * z + 10 * a + i == 50100 && mt == int'(MT_NT2A)) mt = int'(MT_N2A);
      if (mt == 18 || mt == 19 || mt == 20 || mt == 21 || mt == 38)
        return mk_daughter(-1, ERR_OK, 0);
      da = 0;
      dz = 0;
      case (mt)
        4:   ;
        16:  da = -1;
        17:  da = -2;
        22:  begin da = -4;  dz = -2; end
        23:  begin da = -12; dz = -6; end
        24:  begin da = -5;  dz = -2; end
        25:  begin da = -6;  dz = -2; end
        28:  begin da = -1;  dz = -1; end
        29:  begin da = -8;  dz = -4; end
        30:  begin da = -9;  dz = -4; end
        32:  begin da = -2;  dz = -1; end
        33:  begin da = -3;  dz = -1; end
        34:  begin da = -3;  dz = -2; end
        35:  begin da = -10; dz = -5; end
        36:  begin da = -11; dz = -5; end
        37:  da = -3;
        41:  begin da = -2;  dz = -1; end
        42:  begin da = -3;  dz = -1; end
        44:  begin da = -2;  dz = -2; end
        45:  begin da = -5;  dz = -3; end
        102: da = 1;
        103: dz = -1;
        104: begin da = -1;  dz = -1; end
        105: begin da = -2;  dz = -1; end
        106: begin da = -2;  dz = -2; end
        107: begin da = -3;  dz = -2; end
        108: begin da = -7;  dz = -4; end
        109: begin da = -11; dz = -6; end
        111: begin da = -1;  dz = -2; end
        112: begin da = -4;  dz = -3; end
        113: begin da = -10; dz = -5; end
        114: begin da = -9;  dz = -5; end
        115: begin da = -2;  dz = -2; end
        116: begin da = -3;  dz = -2; end
        117: begin da = -5;  dz = -3; end
        default: ;
      endcase
      a += da;
      z += dz;
      case (mt)
        int'(MT_BETA_M):  z += 1;
        int'(MT_BETA_P):  z -= 1;
        int'(MT_IT): begin
          if (i == 0) return mk_daughter(0, ERR_IT_GROUND, 0);
          i = 0;
        end
        int'(MT_ALPHA):   begin a -= 4; z -= 2; end
        int'(MT_NEUTRON): a -= 1;
        int'(MT_SF):      return mk_daughter(-2, ERR_OK, 0);
        int'(MT_PROTON):  begin a -= 1; z -= 1; end
        default: ;
      endcase
      if (mt > int'(MT_SECONDARY)) return mk_daughter(10 * (md[n] - 20000), ERR_OK, 0);
      // partial-reaction bands
      if (mt > 599 && mt < 650) z -= 1;
      if (mt > 649 && mt < 700) begin a -= 1; z -= 1; end
      if (mt > 699 && mt < 750) begin a -= 2; z -= 1; end
      if (mt > 749 && mt < 800) begin a -= 2; z -= 2; end
      if (mt > 799 && mt < 850) begin a -= 3; z -= 2; end
      if (mt > 874 && mt < 892) a -= 1;
    end
    if (md[0] == int'(MT_INELASTIC)) begin
      if (fin == inc) return mk_daughter(0, ERR_INEL_SAME, 0);
    end else if (z == 0) begin
      return mk_daughter(0, ERR_Z_ZERO, 0);
    end else if (10000 * z + 10 * a + i == zai) begin
      return mk_daughter(0, ERR_OK, 0);
    end
    newid = 10000 * z + 10 * a + fin;
    diff  = newid / 10 - zai / 10;
    if (md[0] != int'(MT_INELASTIC)) begin
      d = zai - newid;
      if (diff == 0 && d != 1 && d != 2 && d != 3) return mk_daughter(0, ERR_BAD_IT, 0);
    end
    ok = 1'b0;
    foreach (accepted[k]) if (accepted[k] == diff) ok = 1'b1;
    return mk_daughter(newid, ERR_OK, !ok);
  endfunction

  function automatic record_t mk_record(bit skip, int pid, int inc, int fin,
                                        int m0, int m1, int m2, int m3, int m4);
    record_t r;
    r.skip     = skip;
    r.pid      = ID_W'(pid);
    r.inc      = ST_W'(inc);
    r.fin      = ST_W'(fin);
    r.modes[0] = MODE_W'(m0);
    r.modes[1] = MODE_W'(m1);
    r.modes[2] = MODE_W'(m2);
    r.modes[3] = MODE_W'(m3);
    r.modes[4] = MODE_W'(m4);
    return r;
  endfunction

  function automatic dir_row_t row(record_t r, bit typed = 0, int prod = 0,
                                   logic [ERR_W-1:0] err = ERR_OK, bit unusual = 0);
    dir_row_t t;
    t.rec   = r;
    t.typed = typed;
    t.want  = mk_daughter(prod, err, unusual);
    return t;
  endfunction

  // Random record: usually meaningful codes then terminators, sometimes any codes at all.
  function automatic record_t rand_record();
    int codes [] = '{4, 16, 17, 18, 22, 23, 28, 33, 37, 44, 102, 103, 107, 108, 113,
                     117, 600, 649, 650, 700, 750, 849, 875, 891, 10001, 10002, 10003,
                     10004, 10005, 10006, 10007, 20001};
    record_t r;
    int len;
    r = mk_record($urandom_range(0, 19) == 0, $urandom_range(0, 1299999),
                  $urandom_range(0, 9), $urandom_range(0, 9), 0, 0, 0, 0, 0);
    if ($urandom_range(0, 4) == 0) begin
      // noise: any code at all
      foreach (r.modes[n]) r.modes[n] = MODE_W'($urandom);
    end else begin
      len = $urandom_range(1, NUM_MODE_INPUTS);
      for (int n = 0; n < NUM_MODE_INPUTS; n++)
        if (n < len) r.modes[n] = MODE_W'(codes[$urandom_range(0, codes.size() - 1)]);
        else r.modes[n] = $urandom_range(0, 1) ? MT_DECAY : '0;
      if ($urandom_range(0, 3) == 0) r.pid = ID_W'(50100);  // boron-10
    end
    return r;
  endfunction

  // Offer one word at the current edge and hold it until taken.
  task automatic offer(record_t r);
    s_tvalid <= 1'b1;
    s_tdata  <= {1'b0, r.modes[4], r.modes[3], r.modes[2], r.modes[1], r.modes[0],
                 r.fin, r.inc, r.pid};
    s_tuser  <= r.skip;
    @(negedge clk);
    while (!s_tready) @(negedge clk);
    words_in++;
    @(posedge clk);
  endtask

  task automatic send(record_t r, daughter_t want);
    // idle about 30% of the time, except for a quiet stretch in the middle
    if (!(words_in > 150 && words_in < 260) && $urandom_range(0, 99) < 30) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    offer_with(r, want);
  endtask

  task automatic offer_with(record_t r, daughter_t want);
    pending_daughters.push_back(want);
    offer(r);
  endtask

  // Receiver: random stalls, one long hold-off once the pipe has seen traffic.
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      m_tready <= 1'b0;
    end else if (!hold_done && words_in >= 100) begin
      hold_done <= 1'b1;
      hold_cnt  <= HOLD_LEN;
      m_tready  <= 1'b0;
    end else if (words_in > 150 && words_in < 260) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= $urandom_range(0, 99) >= 30;
    end
  end

  // Compare at the falling edge; the word is taken at the next rising edge.
  always @(negedge clk) begin
    daughter_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_daughters.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, m_tdata);
        mismatch_cnt++;
      end else begin
        want = pending_daughters.pop_front();
        if (m_tdata[22:0] !== want.prod) begin
          $display("%0t: product_code expected %0d actual %0d", $time, want.prod,
                   $signed(m_tdata[22:0]));
          mismatch_cnt++;
        end
        if (m_tdata[25:23] !== want.err) begin
          $display("%0t: error_code expected %0d actual %0d", $time, want.err,
                   m_tdata[25:23]);
          mismatch_cnt++;
        end
        if (m_tdata[26] !== want.unusual) begin
          $display("%0t: unusual_change expected %0d actual %0d", $time, want.unusual,
                   m_tdata[26]);
          mismatch_cnt++;
        end
        if (m_tdata[31:27] !== 5'd0) begin
          $display("%0t: pad bits expected 0 actual %h", $time, m_tdata[31:27]);
          mismatch_cnt++;
        end
      end
    end
  end

  // Watchdog on cycles where no word moves on either side.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_MAX) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin
    dir_row_t dir_tbl[$];
    daughter_t want;
    int wait_cnt;
    dir_tbl.push_back(row(mk_record(1, 922350, 0, 0, 18, 0, 0, 0, 0), 1, 0, ERR_OK));
    dir_tbl.push_back(row(mk_record(0, 260000, 0, 0, 102, 0, 0, 0, 0), 1, 0, ERR_OK));
    dir_tbl.push_back(row(mk_record(0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, ERR_OK));
    dir_tbl.push_back(row(mk_record(0, 922350, 0, 0, 18, 0, 0, 0, 0), 1, -1, ERR_OK));
    dir_tbl.push_back(row(mk_record(0, 922380, 0, 0, 10006, 0, 0, 0, 0), 1, -2, ERR_OK));
    dir_tbl.push_back(row(mk_record(0, 952420, 0, 0, 10003, 0, 0, 0, 0), 1, 0,
                          ERR_IT_GROUND));
    dir_tbl.push_back(row(mk_record(0, 260560, 1, 1, 4, 0, 0, 0, 0), 1, 0, ERR_INEL_SAME));
    dir_tbl.push_back(row(mk_record(0, 10020, 0, 0, 10002, 0, 0, 0, 0), 1, 0, ERR_Z_ZERO));
    dir_tbl.push_back(row(mk_record(0, 922351, 0, 1, 10003, 0, 0, 0, 0), 1, 0, ERR_BAD_IT));
    dir_tbl.push_back(row(mk_record(0, 10010, 0, 0, 20001, 0, 0, 0, 0), 1, 10, ERR_OK));
    dir_tbl.push_back(row(mk_record(0, 10010, 0, 0, 262143, 0, 0, 0, 0), 1, 2421430,
                          ERR_OK));
    dir_tbl.push_back(row(mk_record(0, 50100, 0, 0, 113, 0, 0, 0, 0)));
    dir_tbl.push_back(row(mk_record(0, 50100, 0, 0, 16, 0, 0, 0, 0)));
    dir_tbl.push_back(row(mk_record(0, 1299999, 15, 15, 102, 16, 600, 650, 700)));
    dir_tbl.push_back(row(mk_record(0, 1299999, 9, 0, 750, 800, 875, 10005, 10007)));
    dir_tbl.push_back(row(mk_record(0, 922351, 1, 0, 10003, 10001, 10004, 0, 22)));
    dir_tbl.push_back(row(mk_record(0, 260560, 0, 2, 4, 10000, 107, 0, 0)));
    dir_tbl.push_back(row(mk_record(0, 30060, 0, 0, 23, 23, 0, 0, 0)));
    dir_tbl.push_back(row(mk_record(0, 10010, 0, 0, 109, 36, 45, 117, 114)));
    dir_tbl.push_back(row(mk_record(0, 922350, 0, 0, 999, 12345, 891, 599, 849)));
    dir_tbl.push_back(row(mk_record(0, 942390, 0, 0, 102, 10001, 10001, 10001, 10001)));
    dir_tbl.push_back(row(mk_record(0, 1010, 0, 0, 10002, 10002, 0, 0, 0)));

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tbl[k]) begin
      want = dir_tbl[k].typed ? dir_tbl[k].want : predict_daughter(dir_tbl[k].rec);
      send(dir_tbl[k].rec, want);
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      record_t r;
      r = rand_record();
      send(r, predict_daughter(r));
    end
    s_tvalid <= 1'b0;

    // drain, then give stray words time to show up
    wait_cnt = 0;
    while (pending_daughters.size() != 0 && wait_cnt < 100 * IDLE_MAX) begin
      @(posedge clk);
      wait_cnt++;
    end
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatch_cnt == 0 && pending_daughters.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
`default_nettype wire
